FILE: hw/rtl/tfr_pkg.sv
// Shared constants, codes and types of the triangle fill rasterizer.
package tfr_pkg;

    localparam int FB_WIDTH  = 256;
    localparam int FB_HEIGHT = 256;
    localparam int PIX_COUNT = FB_WIDTH * FB_HEIGHT;
    localparam int PIX_AW    = $clog2(PIX_COUNT);
    localparam int X_W       = $clog2(FB_WIDTH);
    localparam int Y_W       = $clog2(FB_HEIGHT);

    localparam int CRD_W   = 13;
    localparam int DIF_W   = CRD_W + 1;
    localparam int PROD_W  = 2 * DIF_W;
    localparam int ACC_W   = 32;
    localparam int COUNT_W = 17;
    localparam int PIX_W   = 32;

    typedef logic [1:0]             cmd_t;
    typedef logic [1:0]             status_t;
    typedef logic signed [CRD_W-1:0] crd_t;
    typedef logic [PIX_W-1:0]       pixel_t;
    typedef logic [COUNT_W-1:0]     count_t;

    localparam cmd_t CMD_FILL  = 2'd0;
    localparam cmd_t CMD_CLEAR = 2'd1;
    localparam cmd_t CMD_READ  = 2'd2;

    localparam status_t STAT_DONE    = 2'd0;
    localparam status_t STAT_CULLED  = 2'd1;
    localparam status_t STAT_DEGEN   = 2'd2;
    localparam status_t STAT_OUTSIDE = 2'd3;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_AREA0,
        S_AREA1,
        S_DEN0,
        S_DEN1,
        S_E1A,
        S_E1B,
        S_E2A,
        S_E2B,
        S_PREP,
        S_WALK,
        S_READ,
        S_RDATA
    } state_t;

endpackage

FILE: hw/rtl/triangle_fill_rasterizer.sv
// Triangle fill rasterizer: edge-function fill, clear and pixel read over a frame memory.
//
//  channel   signals                               transfer
//  command   start, busy, command, vertex_*,       start high and busy low
//            color_rgba, read_x, read_y
//  result    done, status, pixel_rgba,             done high, one cycle
//            pixels_written
//  config    cfg_valid, cfg_ready, cfg_data        cfg_valid and cfg_ready high
//
//  Fill: setup states on one shared 14x14 multiplier, then one pixel of the clipped
//  bounding box per cycle (one frame memory write port), then the result.
//  Clear: one memory word per cycle. Read: S_READ, then S_RDATA, then the result.
//  After reset the block sweeps zeros through every memory word with busy high.
//  Results are never held off.
module triangle_fill_rasterizer
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tfr_pkg::cmd_t          command,
    input  tfr_pkg::crd_t          vertex_a_x,
    input  tfr_pkg::crd_t          vertex_a_y,
    input  tfr_pkg::crd_t          vertex_b_x,
    input  tfr_pkg::crd_t          vertex_b_y,
    input  tfr_pkg::crd_t          vertex_c_x,
    input  tfr_pkg::crd_t          vertex_c_y,
    input  tfr_pkg::pixel_t        color_rgba,
    input  logic [7:0]             read_x,
    input  logic [7:0]             read_y,
    output logic                   done,
    output tfr_pkg::status_t       status,
    output tfr_pkg::pixel_t        pixel_rgba,
    output tfr_pkg::count_t        pixels_written,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);
    import tfr_pkg::*;

    localparam crd_t X_MAX = CRD_W'(FB_WIDTH - 1);
    localparam crd_t Y_MAX = CRD_W'(FB_HEIGHT - 1);

    typedef logic signed [DIF_W-1:0]  dif_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    function automatic dif_t sdiff(input crd_t a, input crd_t b);
        sdiff = dif_t'(a) - dif_t'(b);
    endfunction

    function automatic acc_t dext(input dif_t d);
        dext = {{(ACC_W-DIF_W){d[DIF_W-1]}}, d};
    endfunction

    function automatic crd_t min3(input crd_t a, input crd_t b, input crd_t c);
        crd_t m;
        m = (a < b) ? a : b;
        min3 = (m < c) ? m : c;
    endfunction

    function automatic crd_t max3(input crd_t a, input crd_t b, input crd_t c);
        crd_t m;
        m = (a > b) ? a : b;
        max3 = (m > c) ? m : c;
    endfunction

    function automatic logic agrees(input acc_t e, input acc_t d);
        agrees = (e == '0) || (e[ACC_W-1] == d[ACC_W-1]);
    endfunction

    state_t state_reg, state_next;
    logic   cull_enable_reg;
    logic   done_reg, done_next;

    crd_t   ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    crd_t   ax_next, ay_next, bx_next, by_next, cx_next, cy_next;
    crd_t   x0_reg, x1_reg, y0_reg, y1_reg;
    crd_t   x0_next, x1_next, y0_next, y1_next;
    pixel_t color_reg, color_next;
    acc_t   acc_reg, acc_next;
    acc_t   denom_reg, denom_next;
    acc_t   e1_reg, e1_next, e2_reg, e2_next;
    acc_t   e1row_reg, e1row_next, e2row_reg, e2row_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [Y_W-1:0]    y_reg, y_next;
    logic [PIX_AW-1:0] addr_reg, addr_next;
    logic [PIX_AW-1:0] row_reg, row_next;
    status_t status_reg, status_next;
    pixel_t  pixel_reg, pixel_next;
    count_t  cnt_reg, cnt_next;

    pixel_t  frame_mem [PIX_COUNT];
    pixel_t  rd_data_reg;
    logic    mem_we;
    pixel_t  mem_wdata;

    dif_t  mul_a, mul_b;
    prod_t prod;
    acc_t  prod_ext;
    dif_t  sx1, sy1, sx2, sy2;
    acc_t  e0;
    logic  pix_in, last_addr, cull_hit, denom_zero, box_empty, x_end, y_end, rd_in_range;
    logic [PIX_AW-1:0] rd_addr, prep_addr;

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign pixel_rgba     = pixel_reg;
    assign pixels_written = cnt_reg;
    assign cfg_ready      = 1'b1;

    assign sx1 = sdiff(by_reg, cy_reg);
    assign sy1 = sdiff(cx_reg, bx_reg);
    assign sx2 = sdiff(cy_reg, ay_reg);
    assign sy2 = sdiff(ax_reg, cx_reg);

    assign prod     = mul_a * mul_b;
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    assign e0     = denom_reg - e1_reg - e2_reg;
    assign pix_in = agrees(e0, denom_reg) && agrees(e1_reg, denom_reg)
                    && agrees(e2_reg, denom_reg);

    assign last_addr   = (addr_reg == PIX_AW'(PIX_COUNT - 1));
    assign cull_hit    = cull_enable_reg && !acc_reg[ACC_W-1];
    assign denom_zero  = (acc_reg == '0);
    assign box_empty   = (x0_reg > x1_reg) || (y0_reg > y1_reg);
    assign x_end       = (x_reg == x1_reg[X_W-1:0]);
    assign y_end       = (y_reg == y1_reg[Y_W-1:0]);
    assign rd_in_range = (32'(read_x) < 32'(FB_WIDTH)) && (32'(read_y) < 32'(FB_HEIGHT));
    assign rd_addr     = PIX_AW'(PIX_AW'(read_y) * PIX_AW'(FB_WIDTH) + PIX_AW'(read_x));
    assign prep_addr   = PIX_AW'(PIX_AW'(y0_reg[Y_W-1:0]) * PIX_AW'(FB_WIDTH)
                                 + PIX_AW'(x0_reg[X_W-1:0]));

    always_comb
    begin
        unique case (state_reg)
            S_AREA0:
            begin
                mul_a = sdiff(bx_reg, ax_reg);
                mul_b = sdiff(cy_reg, ay_reg);
            end
            S_AREA1:
            begin
                mul_a = sdiff(by_reg, ay_reg);
                mul_b = sdiff(cx_reg, ax_reg);
            end
            S_DEN0:
            begin
                mul_a = sx1;
                mul_b = sy2;
            end
            S_DEN1:
            begin
                mul_a = sy1;
                mul_b = sdiff(ay_reg, cy_reg);
            end
            S_E1A:
            begin
                mul_a = sx1;
                mul_b = sdiff(x0_reg, cx_reg);
            end
            S_E1B:
            begin
                mul_a = sy1;
                mul_b = sdiff(y0_reg, cy_reg);
            end
            S_E2A:
            begin
                mul_a = sx2;
                mul_b = sdiff(x0_reg, cx_reg);
            end
            S_E2B:
            begin
                mul_a = sy2;
                mul_b = sdiff(y0_reg, cy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:  if (last_addr) state_next = S_IDLE;
            S_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_FILL:  state_next = S_AREA0;
                        CMD_CLEAR: state_next = S_CLEAR;
                        CMD_READ:  if (rd_in_range) state_next = S_READ;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: if (last_addr) state_next = S_IDLE;
            S_AREA0: state_next = S_AREA1;
            S_AREA1: state_next = S_DEN0;
            S_DEN0:  state_next = cull_hit ? S_IDLE : S_DEN1;
            S_DEN1:  state_next = S_E1A;
            S_E1A:   state_next = denom_zero ? S_IDLE : S_E1B;
            S_E1B:   state_next = S_E2A;
            S_E2A:   state_next = S_E2B;
            S_E2B:   state_next = S_PREP;
            S_PREP:  state_next = box_empty ? S_IDLE : S_WALK;
            S_WALK:  if (x_end && y_end) state_next = S_IDLE;
            S_READ:  state_next = S_RDATA;
            S_RDATA: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        done_next   = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = color_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x0_next     = x0_reg;
        x1_next     = x1_reg;
        y0_next     = y0_reg;
        y1_next     = y1_reg;
        color_next  = color_reg;
        acc_next    = acc_reg;
        denom_next  = denom_reg;
        e1_next     = e1_reg;
        e2_next     = e2_reg;
        e1row_next  = e1row_reg;
        e2row_next  = e2row_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        addr_next   = addr_reg;
        row_next    = row_reg;
        status_next = status_reg;
        pixel_next  = pixel_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                addr_next = addr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ax_next     = vertex_a_x;
                    ay_next     = vertex_a_y;
                    bx_next     = vertex_b_x;
                    by_next     = vertex_b_y;
                    cx_next     = vertex_c_x;
                    cy_next     = vertex_c_y;
                    color_next  = color_rgba;
                    status_next = STAT_DONE;
                    pixel_next  = '0;
                    cnt_next    = '0;
                    addr_next   = '0;
                    case (command) inside
                        CMD_FILL, CMD_CLEAR: ;
                        CMD_READ:
                        begin
                            addr_next = rd_addr;
                            if (!rd_in_range)
                            begin
                                status_next = STAT_OUTSIDE;
                                done_next   = 1'b1;
                            end
                        end
                        default: done_next = 1'b1;
                    endcase
                end
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (last_addr)
                begin
                    cnt_next  = COUNT_W'(PIX_COUNT);
                    done_next = 1'b1;
                end
            end
            S_AREA0:
            begin
                acc_next = prod_ext;
                x0_next  = min3(ax_reg, bx_reg, cx_reg);
                x1_next  = max3(ax_reg, bx_reg, cx_reg);
                y0_next  = min3(ay_reg, by_reg, cy_reg);
                y1_next  = max3(ay_reg, by_reg, cy_reg);
                if (x0_next < 0)     x0_next = '0;
                if (x1_next > X_MAX) x1_next = X_MAX;
                if (y0_next < 0)     y0_next = '0;
                if (y1_next > Y_MAX) y1_next = Y_MAX;
            end
            S_AREA1: acc_next = acc_reg - prod_ext;
            S_DEN0:
            begin
                acc_next = prod_ext;
                if (cull_hit)
                begin
                    status_next = STAT_CULLED;
                    done_next   = 1'b1;
                end
            end
            S_DEN1: acc_next = acc_reg + prod_ext;
            S_E1A:
            begin
                denom_next = acc_reg;
                acc_next   = prod_ext;
                if (denom_zero)
                begin
                    status_next = STAT_DEGEN;
                    done_next   = 1'b1;
                end
            end
            S_E1B: acc_next = acc_reg + prod_ext;
            S_E2A:
            begin
                e1row_next = acc_reg;
                acc_next   = prod_ext;
            end
            S_E2B: acc_next = acc_reg + prod_ext;
            S_PREP:
            begin
                e1_next    = e1row_reg;
                e2_next    = acc_reg;
                e2row_next = acc_reg;
                x_next     = x0_reg[X_W-1:0];
                y_next     = y0_reg[Y_W-1:0];
                addr_next  = prep_addr;
                row_next   = prep_addr;
                if (box_empty)
                begin
                    done_next = 1'b1;
                end
            end
            S_WALK:
            begin
                mem_we   = pix_in;
                cnt_next = cnt_reg + COUNT_W'(pix_in);
                if (x_end)
                begin
                    if (y_end)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        x_next     = x0_reg[X_W-1:0];
                        y_next     = y_reg + 1'b1;
                        e1row_next = e1row_reg + dext(sy1);
                        e2row_next = e2row_reg + dext(sy2);
                        e1_next    = e1row_next;
                        e2_next    = e2row_next;
                        row_next   = row_reg + PIX_AW'(FB_WIDTH);
                        addr_next  = row_next;
                    end
                end
                else
                begin
                    x_next    = x_reg + 1'b1;
                    e1_next   = e1_reg + dext(sx1);
                    e2_next   = e2_reg + dext(sx2);
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_READ: ;
            S_RDATA:
            begin
                pixel_next = rd_data_reg;
                done_next  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            cull_enable_reg <= 1'b1;
            done_reg        <= 1'b0;
            addr_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            addr_reg  <= addr_next;
            if (cfg_valid && cfg_ready)
            begin
                cull_enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        x0_reg     <= x0_next;
        x1_reg     <= x1_next;
        y0_reg     <= y0_next;
        y1_reg     <= y1_next;
        color_reg  <= color_next;
        acc_reg    <= acc_next;
        denom_reg  <= denom_next;
        e1_reg     <= e1_next;
        e2_reg     <= e2_next;
        e1row_reg  <= e1row_next;
        e2row_reg  <= e2row_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        row_reg    <= row_next;
        status_reg <= status_next;
        pixel_reg  <= pixel_next;
        cnt_reg    <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[addr_reg] <= mem_wdata;
        end
        rd_data_reg <= frame_mem[addr_reg];
    end

endmodule

FILE: hw/rtl/tfr_checker.sv
// Port-level checks for the triangle fill rasterizer, bound to the top level.
module tfr_checker
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input tfr_pkg::status_t       status,
    input tfr_pkg::pixel_t        pixel_rgba,
    input tfr_pkg::count_t        pixels_written
);
    import tfr_pkg::*;

    // result shows only once the command has finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted command neither started nor finished");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STAT_OUTSIDE |-> pixel_rgba == '0 && pixels_written == '0)
        else $error("outside read returned data");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STAT_CULLED || status == STAT_DEGEN)
        |-> pixels_written == '0 && pixel_rgba == '0)
        else $error("rejected triangle reported writes");

endmodule

bind triangle_fill_rasterizer tfr_checker u_tfr_checker (.*);

FILE: tb/sv/tb_triangle_fill_rasterizer.sv
// Triangle fill rasterizer testbench: directed and random commands checked against a shadow frame store.
module tb_triangle_fill_rasterizer;
    timeunit 1ns;
    timeprecision 1ps;

    import tfr_pkg::*;

    localparam cmd_t CMD_NOP = 2'd3;

    typedef struct {
        cmd_t       op;
        crd_t       ax, ay, bx, by, cx, cy;
        pixel_t     color;
        logic [7:0] rx, ry;
    } raster_cmd_t;

    typedef struct {
        status_t status;
        pixel_t  pixel;
        count_t  count;
    } raster_res_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    cmd_t       command = CMD_FILL;
    crd_t       vertex_a_x = '0;
    crd_t       vertex_a_y = '0;
    crd_t       vertex_b_x = '0;
    crd_t       vertex_b_y = '0;
    crd_t       vertex_c_x = '0;
    crd_t       vertex_c_y = '0;
    pixel_t     color_rgba = '0;
    logic [7:0] read_x = '0;
    logic [7:0] read_y = '0;
    logic       done;
    status_t    status;
    pixel_t     pixel_rgba;
    count_t     pixels_written;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    triangle_fill_rasterizer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .vertex_a_x     (vertex_a_x),
        .vertex_a_y     (vertex_a_y),
        .vertex_b_x     (vertex_b_x),
        .vertex_b_y     (vertex_b_y),
        .vertex_c_x     (vertex_c_x),
        .vertex_c_y     (vertex_c_y),
        .color_rgba     (color_rgba),
        .read_x         (read_x),
        .read_y         (read_y),
        .done           (done),
        .status         (status),
        .pixel_rgba     (pixel_rgba),
        .pixels_written (pixels_written),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pixel_t      shadow_fb [PIX_COUNT];
    bit          shadow_cull = 1'b1;
    raster_cmd_t cmd_queue [$];
    raster_res_t expected_res [$];
    raster_cmd_t drive_cmd;
    bit          cmd_taken = 1'b0;
    int          send_idle_pct = 0;
    int          err_count = 0;
    int          last_x = 0;
    int          last_y = 0;

    function automatic longint tri_area(input raster_cmd_t c);
        longint ax, ay, bx, by, cx, cy;
        ax = c.ax; ay = c.ay; bx = c.bx; by = c.by; cx = c.cx; cy = c.cy;
        return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    endfunction

    function automatic longint lo3(input longint a, input longint b, input longint c);
        longint m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic longint hi3(input longint a, input longint b, input longint c);
        longint m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Updates the shadow store as the block would and returns its result.
    function automatic raster_res_t predict_result(input raster_cmd_t c);
        raster_res_t r;
        longint      ax, ay, bx, by, cx, cy, den, e0, e1, e2, x0, x1, y0, y1;
        int unsigned n;
        r = '{STAT_DONE, '0, '0};
        n = 0;
        ax = c.ax; ay = c.ay; bx = c.bx; by = c.by; cx = c.cx; cy = c.cy;
        case (c.op)
            CMD_FILL:
            begin
                den = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
                if (shadow_cull && tri_area(c) >= 0)
                    r.status = STAT_CULLED;
                else if (den == 0)
                    r.status = STAT_DEGEN;
                else
                begin
                    x0 = lo3(ax, bx, cx);
                    if (x0 < 0) x0 = 0;
                    x1 = hi3(ax, bx, cx);
                    if (x1 > FB_WIDTH - 1) x1 = FB_WIDTH - 1;
                    y0 = lo3(ay, by, cy);
                    if (y0 < 0) y0 = 0;
                    y1 = hi3(ay, by, cy);
                    if (y1 > FB_HEIGHT - 1) y1 = FB_HEIGHT - 1;
                    for (longint y = y0; y <= y1; y++)
                        for (longint x = x0; x <= x1; x++)
                        begin
                            e1 = (by - cy) * (x - cx) + (cx - bx) * (y - cy);
                            e2 = (cy - ay) * (x - cx) + (ax - cx) * (y - cy);
                            e0 = den - e1 - e2;
                            if ((e0 == 0 || (e0 > 0) == (den > 0)) &&
                                (e1 == 0 || (e1 > 0) == (den > 0)) &&
                                (e2 == 0 || (e2 > 0) == (den > 0)))
                            begin
                                shadow_fb[y * FB_WIDTH + x] = c.color;
                                n++;
                            end
                        end
                    r.count = n[COUNT_W-1:0];
                end
            end
            CMD_CLEAR:
            begin
                foreach (shadow_fb[i])
                    shadow_fb[i] = c.color;
                r.count = COUNT_W'(PIX_COUNT);
            end
            CMD_READ:
            begin
                if (int'(c.rx) >= FB_WIDTH || int'(c.ry) >= FB_HEIGHT)
                    r.status = STAT_OUTSIDE;
                else
                    r.pixel = shadow_fb[int'(c.ry) * FB_WIDTH + int'(c.rx)];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic raster_cmd_t noise_cmd();
        raster_cmd_t c;
        c.op = cmd_t'($urandom_range(3));
        c.ax = crd_t'($urandom()); c.ay = crd_t'($urandom());
        c.bx = crd_t'($urandom()); c.by = crd_t'($urandom());
        c.cx = crd_t'($urandom()); c.cy = crd_t'($urandom());
        c.color = $urandom();
        c.rx = 8'($urandom_range(255));
        c.ry = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic raster_cmd_t tri_cmd(input int ax, input int ay, input int bx,
                                            input int by, input int cx, input int cy,
                                            input pixel_t col);
        raster_cmd_t c;
        c = noise_cmd();
        c.op = CMD_FILL;
        c.ax = crd_t'(ax); c.ay = crd_t'(ay);
        c.bx = crd_t'(bx); c.by = crd_t'(by);
        c.cx = crd_t'(cx); c.cy = crd_t'(cy);
        c.color = col;
        return c;
    endfunction

    function automatic raster_cmd_t read_cmd(input int x, input int y);
        raster_cmd_t c;
        c = noise_cmd();
        c.op = CMD_READ;
        c.rx = x[7:0];
        c.ry = y[7:0];
        return c;
    endfunction

    function automatic raster_cmd_t clear_cmd(input pixel_t col);
        raster_cmd_t c;
        c = noise_cmd();
        c.op = CMD_CLEAR;
        c.color = col;
        return c;
    endfunction

    // Swap b and c when the doubled area is positive, so it turns negative and the triangle survives culling.
    function automatic raster_cmd_t make_neg(input raster_cmd_t c);
        crd_t tx, ty;
        if (tri_area(c) > 0)
        begin
            tx = c.bx; ty = c.by;
            c.bx = c.cx; c.by = c.cy;
            c.cx = tx; c.cy = ty;
        end
        return c;
    endfunction

    function automatic crd_t rand_span(input int lo, input int hi);
        return crd_t'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic raster_cmd_t random_item();
        raster_cmd_t c;
        int          k, mx, my, side, d;
        k = $urandom_range(99);
        c = noise_cmd();
        if (k < 55)
        begin
            mx = int'($urandom_range(295)) - 20;
            my = int'($urandom_range(295)) - 20;
            c = tri_cmd(mx + int'($urandom_range(48)) - 24, my + int'($urandom_range(48)) - 24,
                        mx + int'($urandom_range(48)) - 24, my + int'($urandom_range(48)) - 24,
                        mx + int'($urandom_range(48)) - 24, my + int'($urandom_range(48)) - 24,
                        $urandom());
            if (shadow_cull || $urandom_range(1))
                c = make_neg(c);
            last_x = (int'(c.ax) + int'(c.bx) + int'(c.cx)) / 3;
            last_y = (int'(c.ay) + int'(c.by) + int'(c.cy)) / 3;
        end
        else if (k < 63)
        begin
            // box entirely off the store, coordinates over the full range
            c.op = CMD_FILL;
            side = $urandom_range(3);
            case (side)
                0: begin c.ax = rand_span(256, 4095); c.bx = rand_span(256, 4095);
                         c.cx = rand_span(256, 4095); end
                1: begin c.ax = rand_span(-4096, -1); c.bx = rand_span(-4096, -1);
                         c.cx = rand_span(-4096, -1); end
                2: begin c.ay = rand_span(256, 4095); c.by = rand_span(256, 4095);
                         c.cy = rand_span(256, 4095); end
                default: begin c.ay = rand_span(-4096, -1); c.by = rand_span(-4096, -1);
                               c.cy = rand_span(-4096, -1); end
            endcase
            if ($urandom_range(3) != 0)
                c = make_neg(c);
        end
        else if (k < 68)
        begin
            mx = $urandom_range(255);
            my = $urandom_range(255);
            d = int'($urandom_range(20)) - 10;
            c = tri_cmd(mx, my, mx + d, my - d, mx + 2 * d, my - 2 * d, $urandom());
        end
        else if (k < 72)
            c.op = CMD_NOP;
        else if (k < 86)
            c = read_cmd(last_x < 0 ? 0 : (last_x > 255 ? 255 : last_x),
                         last_y < 0 ? 0 : (last_y > 255 ? 255 : last_y));
        else
            c.op = CMD_READ;
        return c;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endtask

    task automatic write_cull(input bit v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        shadow_cull = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle(input int settle);
        while (cmd_queue.size() != 0 || expected_res.size() != 0 || start || busy !== 1'b0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // command driver
    always @(negedge clk)
    begin : drive_proc
        raster_cmd_t nxt;
        if (rst_n)
        begin
            if (start && !cmd_taken)
                ;
            else if (cmd_queue.size() != 0 && int'($urandom_range(99)) >= send_idle_pct)
            begin
                nxt = cmd_queue.pop_front();
                drive_cmd  = nxt;
                command    <= nxt.op;
                vertex_a_x <= nxt.ax;
                vertex_a_y <= nxt.ay;
                vertex_b_x <= nxt.bx;
                vertex_b_y <= nxt.by;
                vertex_c_x <= nxt.cx;
                vertex_c_y <= nxt.cy;
                color_rgba <= nxt.color;
                read_x     <= nxt.rx;
                read_y     <= nxt.ry;
                start      <= 1'b1;
            end
            else
                start <= 1'b0;
            cmd_taken = 1'b0;
        end
    end

    // result monitor and command transfer capture
    always @(posedge clk)
    begin : watch_proc
        raster_res_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (expected_res.size() == 0)
                    flag_error($sformatf("unexpected result: status %0d pixel %08h count %0d",
                                         status, pixel_rgba, pixels_written));
                else
                begin
                    want = expected_res.pop_front();
                    if (status !== want.status || pixel_rgba !== want.pixel ||
                        pixels_written !== want.count)
                        flag_error($sformatf(
                            "mismatch: status %0d/%0d pixel %08h/%08h count %0d/%0d (exp/act)",
                            want.status, status, want.pixel, pixel_rgba,
                            want.count, pixels_written));
                end
            end
            if (start && busy === 1'b0)
            begin
                expected_res.push_back(predict_result(drive_cmd));
                cmd_taken = 1'b1;
            end
        end
    end

    initial
    begin
        foreach (shadow_fb[i])
            shadow_fb[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_idle(4);

        write_cull(1'b1);
        cmd_queue.push_back(read_cmd(0, 0));
        cmd_queue.push_back(read_cmd(255, 255));
        cmd_queue.push_back(tri_cmd(10, 10, 20, 35, 40, 12, 32'h11223344));
        cmd_queue.push_back(read_cmd(23, 19));
        cmd_queue.push_back(tri_cmd(10, 10, 40, 12, 20, 35, 32'h55667788));
        cmd_queue.push_back(tri_cmd(7, 7, 7, 7, 7, 7, 32'hDEADBEEF));
        cmd_queue.push_back(make_neg(tri_cmd(4095, 4095, 300, 4095, 4095, 300, 32'hFFFFFFFF)));
        cmd_queue.push_back(make_neg(tri_cmd(-4096, -4096, -1, -4096, -4096, -1, '1)));
        begin : nop_item
            raster_cmd_t c;
            c = noise_cmd();
            c.op = CMD_NOP;
            cmd_queue.push_back(c);
        end
        cmd_queue.push_back(clear_cmd(32'hFFFFFFFF));
        cmd_queue.push_back(read_cmd(255, 0));
        cmd_queue.push_back(make_neg(tri_cmd(-200, -200, 900, -100, -100, 900, 32'h80FF0001)));
        cmd_queue.push_back(read_cmd(128, 128));
        cmd_queue.push_back(read_cmd(0, 255));
        wait_idle(4);

        write_cull(1'b0);
        cmd_queue.push_back(tri_cmd(7, 7, 7, 7, 7, 7, 32'h01010101));
        cmd_queue.push_back(tri_cmd(0, 0, 5, 5, 10, 10, 32'h02020202));
        cmd_queue.push_back(tri_cmd(10, 10, 40, 12, 20, 35, 32'h0000FF00));
        cmd_queue.push_back(read_cmd(25, 20));
        cmd_queue.push_back(tri_cmd(200, 200, 250, 240, 210, 255, 32'h00FF0000));
        cmd_queue.push_back(tri_cmd(-30, -30, 40, -5, -5, 40, 32'h7F000000));
        cmd_queue.push_back(tri_cmd(240, 240, 300, 250, 250, 300, 32'h000000FF));
        cmd_queue.push_back(read_cmd(255, 255));
        cmd_queue.push_back(read_cmd(0, 0));
        wait_idle(4);

        for (int p = 0; p < 4; p++)
        begin
            write_cull(p % 2 == 0);
            case (p)
                0: send_idle_pct = 66;
                1: send_idle_pct = 28;
                2: send_idle_pct = 0;
                default: send_idle_pct = 66;
            endcase
            if (p == 1)
                cmd_queue.push_back(clear_cmd($urandom()));
            repeat (20) cmd_queue.push_back(random_item());
            wait_idle(4);
        end

        wait_idle(20);
        if (err_count == 0)
            $display("tb_triangle_fill_rasterizer: PASS");
        else
            $display("tb_triangle_fill_rasterizer: FAIL");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("tb_triangle_fill_rasterizer: FAIL");
        $finish;
    end

endmodule
